>>> sv/mrs_pkg.sv
// shared constants, codes and the operation record for the region statistics block
// depends on nothing; every module but mrs_ram imports it
package mrs_pkg;

    localparam int PAGE_SHIFT = 12;
    localparam int BYTES_W    = 48;
    localparam int PROT_W     = 11;
    localparam int IDX_W      = 6;
    localparam int VAL_W      = 32;
    localparam int PAGES_W    = 32;

    // page number width and the grouping used by the top bit search
    localparam int PG_W      = BYTES_W - PAGE_SHIFT;
    localparam int GRP_W     = 8;
    localparam int GRP_N     = (PG_W + GRP_W - 1) / GRP_W;
    localparam int PG_PAD_W  = GRP_N * GRP_W;
    localparam int GRP_POS_W = $clog2(GRP_W);
    localparam int TOP_W     = $clog2(PG_PAD_W);

    localparam int BIN_COUNT = 36;
    localparam int BIN_W     = $clog2(BIN_COUNT);

    localparam int ACC_N     = 7;
    localparam int KIND_N    = 3;
    localparam int GUARD_BIT = 8;

    // counter index map
    localparam int IDX_FREE      = 0;
    localparam int IDX_MAPPED    = 1;
    localparam int IDX_RESERVED  = 4;
    localparam int IDX_COMMITTED = 5;
    localparam int IDX_GUARD     = 6;
    localparam int IDX_ACCESS    = 7;
    localparam int IDX_BINS      = 14;
    localparam int REG_CNT_N     = IDX_BINS;
    localparam int REG_CNT_W     = $clog2(REG_CNT_N);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // action codes
    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_ACCOUNT = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    // region state codes
    localparam logic [1:0] ST_FREE     = 2'd0;
    localparam logic [1:0] ST_RESERVED = 2'd1;

    // region kind codes
    localparam logic [1:0] KIND_MAPPED  = 2'd0;
    localparam logic [1:0] KIND_PRIVATE = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [PAGES_W-1:0] pages;
        logic               is_free;
        logic               is_resv;
        logic [KIND_N-1:0]  kind_hot;
        logic               guard;
        logic [ACC_N-1:0]   access_hot;
        logic               bin_ok;
        logic [BIN_W-1:0]   bin;
        logic [IDX_W-1:0]   idx;
    } mrs_op_t;

endpackage

>>> sv/memory_region_statistics_core.sv
// Memory region statistics core: page tallies over region descriptors.
// Input side is a queue: drive the item on the field ports with push high;
// the transfer happens on a rising edge where full is low. action selects
// clear, account or read; only a read gives a result, on the output queue.
// Result side: while empty is low the oldest result is on counter_value and
// echoed_index; it is taken on a rising edge where pop is high.
// Throughput is one item per cycle unless a full queue stalls it: every counter
// update is a single add in the back end, and span bins are a read-modify-write
// through the bin ram with a bypass for back-to-back hits on one bin.
// An accepted read passes the input register with the first half of the bin
// search, the op queue, the bin ram read and the result queue before it shows.
// If pop is held low the 4-entry result queue fills, the back end stops
// taking ops, the 4-entry op queue fills and full rises; nothing is lost.
// Reset (rst_n low, asynchronous) empties both queues and zeroes every
// counter at once; the bins use valid bits, so no clearing pass is needed.
// depends on mrs_pkg, mrs_front, mrs_op_queue, mrs_back
module memory_region_statistics_core
    import mrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         action,
    input  logic [BYTES_W-1:0] region_bytes,
    input  logic [1:0]         region_state,
    input  logic [1:0]         region_kind,
    input  logic [PROT_W-1:0]  protect_bits,
    input  logic [IDX_W-1:0]   counter_index,
    output logic               empty,
    input  logic               pop,
    output logic [VAL_W-1:0]   counter_value,
    output logic [IDX_W-1:0]   echoed_index
);

    logic    fq_push;
    logic    fq_full;
    mrs_op_t fq_op;
    logic    bq_pop;
    logic    bq_empty;
    mrs_op_t bq_op;

    mrs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .action        (action),
        .region_bytes  (region_bytes),
        .region_state  (region_state),
        .region_kind   (region_kind),
        .protect_bits  (protect_bits),
        .counter_index (counter_index),
        .q_push        (fq_push),
        .q_op          (fq_op),
        .q_full        (fq_full)
    );

    mrs_op_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fq_push),
        .push_op (fq_op),
        .full    (fq_full),
        .pop     (bq_pop),
        .head_op (bq_op),
        .empty   (bq_empty)
    );

    mrs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (bq_empty),
        .q_op          (bq_op),
        .q_pop         (bq_pop),
        .empty         (empty),
        .pop           (pop),
        .counter_value (counter_value),
        .echoed_index  (echoed_index)
    );

endmodule

>>> sv/mrs_ram.sv
// generic single write port, single read port ram with registered read data
// depends on nothing
module mrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 36
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // a read at the address being written returns the old word
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/mrs_front.sv
// front end: input register, region classification and span bin search
// depends on mrs_pkg
module mrs_front
    import mrs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          action,
    input  logic [BYTES_W-1:0]  region_bytes,
    input  logic [1:0]          region_state,
    input  logic [1:0]          region_kind,
    input  logic [PROT_W-1:0]   protect_bits,
    input  logic [IDX_W-1:0]    counter_index,
    output logic                q_push,
    output mrs_op_t             q_op,
    input  logic                q_full
);

    logic                 f_valid_reg, f_valid_next;
    logic [1:0]           f_action_reg;
    logic [PAGES_W-1:0]   f_pages_reg;
    logic                 f_free_reg;
    logic                 f_resv_reg;
    logic [KIND_N-1:0]    f_kind_reg;
    logic                 f_guard_reg;
    logic [ACC_N-1:0]     f_acc_reg;
    logic [IDX_W-1:0]     f_idx_reg;
    logic [GRP_N-1:0]     grp_nz_reg;
    logic [GRP_POS_W-1:0] grp_pos_reg [GRP_N];

    logic                 accept;
    logic                 advance;
    logic [PG_PAD_W-1:0]  pg_pad;
    logic [GRP_N-1:0]     grp_nz;
    logic [GRP_POS_W-1:0] grp_pos [GRP_N];
    logic [ACC_N-1:0]     acc_raw;
    logic [KIND_N-1:0]    kind_hot;
    logic [TOP_W-1:0]     top_pos;
    logic                 top_found;
    logic [BIN_W-1:0]     bin_sel;
    logic                 act_known;

    assign full    = f_valid_reg && q_full;
    assign accept  = push && !full;
    assign advance = f_valid_reg && !q_full;

    // first half of the top bit search: one leading one per byte group
    assign pg_pad = PG_PAD_W'(region_bytes[BYTES_W-1:PAGE_SHIFT]);

    always_comb
    begin
        for (int g = 0; g < GRP_N; g++)
        begin
            grp_nz[g]  = |pg_pad[g*GRP_W +: GRP_W];
            grp_pos[g] = '0;
            for (int b = 0; b < GRP_W; b++)
            begin
                if (pg_pad[g*GRP_W + b])
                begin
                    grp_pos[g] = GRP_POS_W'(b);
                end
            end
        end
    end

    assign acc_raw = protect_bits[ACC_N-1:0];

    always_comb
    begin
        case (region_kind)
            KIND_MAPPED:  kind_hot = 3'b001;
            KIND_PRIVATE: kind_hot = 3'b100;
            default:      kind_hot = 3'b010;
        endcase
    end

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (accept)
        begin
            f_valid_next = 1'b1;
        end
        else if (advance)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_action_reg <= action;
            f_pages_reg  <= region_bytes[PAGE_SHIFT +: PAGES_W];
            f_free_reg   <= (region_state == ST_FREE);
            f_resv_reg   <= (region_state == ST_RESERVED);
            f_kind_reg   <= kind_hot;
            f_guard_reg  <= protect_bits[GUARD_BIT];
            // lowest set access bit only
            f_acc_reg    <= acc_raw & (~acc_raw + ACC_N'(1));
            f_idx_reg    <= counter_index;
            grp_nz_reg   <= grp_nz;
            for (int g = 0; g < GRP_N; g++)
            begin
                grp_pos_reg[g] <= grp_pos[g];
            end
        end
    end

    // second half: highest non-empty group wins, clamp to the last bin
    always_comb
    begin
        top_pos   = '0;
        top_found = 1'b0;
        for (int g = 0; g < GRP_N; g++)
        begin
            if (grp_nz_reg[g])
            begin
                top_found = 1'b1;
                top_pos   = TOP_W'(g * GRP_W) + TOP_W'(grp_pos_reg[g]);
            end
        end
        if (int'(top_pos) > BIN_COUNT - 1)
        begin
            bin_sel = BIN_W'(BIN_COUNT - 1);
        end
        else
        begin
            bin_sel = BIN_W'(top_pos);
        end
    end

    // unknown actions are dropped here
    assign act_known = (f_action_reg == ACT_CLEAR) || (f_action_reg == ACT_ACCOUNT)
                    || (f_action_reg == ACT_READ);
    assign q_push = advance && act_known;

    always_comb
    begin
        q_op.action     = f_action_reg;
        q_op.pages      = f_pages_reg;
        q_op.is_free    = f_free_reg;
        q_op.is_resv    = f_resv_reg;
        q_op.kind_hot   = f_kind_reg;
        q_op.guard      = f_guard_reg;
        q_op.access_hot = f_acc_reg;
        q_op.bin_ok     = top_found;
        q_op.bin        = bin_sel;
        q_op.idx        = f_idx_reg;
    end

endmodule

>>> sv/mrs_op_queue.sv
// short operation queue between the front end and the counter back end
// depends on mrs_pkg
module mrs_op_queue
    import mrs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  mrs_op_t push_op,
    output logic    full,
    input  logic    pop,
    output mrs_op_t head_op,
    output logic    empty
);

    mrs_op_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] cnt_reg, cnt_next;
    logic                   do_push;
    logic                   do_pop;

    assign full    = (cnt_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head_op = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + QUEUE_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

>>> sv/mrs_back.sv
// back end: counter registers, span bin ram with read-modify-write, result queue
// depends on mrs_pkg and mrs_ram
module mrs_back
    import mrs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  mrs_op_t          q_op,
    output logic             q_pop,
    output logic             empty,
    input  logic             pop,
    output logic [VAL_W-1:0] counter_value,
    output logic [IDX_W-1:0] echoed_index
);

    logic [VAL_W-1:0]     cnt_reg [REG_CNT_N];
    logic [VAL_W-1:0]     cnt_next [REG_CNT_N];
    logic [BIN_COUNT-1:0] vld_reg, vld_next;
    logic                 fwd_valid_reg, fwd_valid_next;
    logic [BIN_W-1:0]     fwd_addr_reg;
    logic [VAL_W-1:0]     fwd_data_reg;

    logic                 m_inc_reg;
    logic                 m_read_reg;
    logic                 m_bin_rd_reg;
    logic [BIN_W-1:0]     m_addr_reg;
    logic [VAL_W-1:0]     m_val_reg;
    logic [IDX_W-1:0]     m_idx_reg;

    logic [VAL_W-1:0]     res_val_reg [OUT_DEPTH];
    logic [IDX_W-1:0]     res_idx_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] res_wr_reg, res_wr_next;
    logic [OUT_PTR_W-1:0] res_rd_reg, res_rd_next;
    logic [OUT_CNT_W-1:0] res_cnt_reg, res_cnt_next;

    logic                 go;
    logic                 is_clear;
    logic                 is_acct;
    logic                 is_read;
    logic                 bin_inc;
    logic                 bin_rd;
    logic [BIN_W-1:0]     ram_raddr;
    logic [VAL_W-1:0]     ram_rdata;
    logic [VAL_W-1:0]     flop_val;
    logic [VAL_W-1:0]     bin_val;
    logic [VAL_W-1:0]     res_val;
    logic                 res_pop;

    // leave room in the result queue for the read in flight
    assign go = !q_empty
             && ((res_cnt_reg + OUT_CNT_W'(m_read_reg)) < OUT_CNT_W'(OUT_DEPTH));
    assign q_pop = go;

    assign is_clear = go && (q_op.action == ACT_CLEAR);
    assign is_acct  = go && (q_op.action == ACT_ACCOUNT);
    assign is_read  = go && (q_op.action == ACT_READ);
    assign bin_inc  = is_acct && q_op.is_free && q_op.bin_ok;
    assign bin_rd   = is_read && (q_op.idx >= IDX_W'(IDX_BINS))
                   && (q_op.idx < IDX_W'(IDX_BINS + BIN_COUNT));
    assign ram_raddr = bin_inc ? q_op.bin : BIN_W'(q_op.idx - IDX_W'(IDX_BINS));

    assign flop_val = (q_op.idx < IDX_W'(REG_CNT_N)) ? cnt_reg[q_op.idx[REG_CNT_W-1:0]] : '0;

    always_comb
    begin
        for (int i = 0; i < REG_CNT_N; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        if (is_clear)
        begin
            for (int i = 0; i < REG_CNT_N; i++)
            begin
                cnt_next[i] = '0;
            end
        end
        else if (is_acct)
        begin
            if (q_op.is_free)
            begin
                cnt_next[IDX_FREE] = cnt_reg[IDX_FREE] + q_op.pages;
            end
            else
            begin
                for (int k = 0; k < KIND_N; k++)
                begin
                    if (q_op.kind_hot[k])
                    begin
                        cnt_next[IDX_MAPPED + k] = cnt_reg[IDX_MAPPED + k] + q_op.pages;
                    end
                end
                if (q_op.is_resv)
                begin
                    cnt_next[IDX_RESERVED] = cnt_reg[IDX_RESERVED] + q_op.pages;
                end
                else
                begin
                    cnt_next[IDX_COMMITTED] = cnt_reg[IDX_COMMITTED] + q_op.pages;
                    if (q_op.guard)
                    begin
                        cnt_next[IDX_GUARD] = cnt_reg[IDX_GUARD] + q_op.pages;
                    end
                    for (int b = 0; b < ACC_N; b++)
                    begin
                        if (q_op.access_hot[b])
                        begin
                            cnt_next[IDX_ACCESS + b] = cnt_reg[IDX_ACCESS + b] + q_op.pages;
                        end
                    end
                end
            end
        end
    end

    mrs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (BIN_COUNT)
    ) u_bins (
        .clk   (clk),
        .we    (m_inc_reg),
        .waddr (m_addr_reg),
        .wdata (bin_val + VAL_W'(1)),
        .re    (bin_inc || bin_rd),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // latest write bypasses the ram; a bin never written since clear reads zero
    assign bin_val = (fwd_valid_reg && (fwd_addr_reg == m_addr_reg)) ? fwd_data_reg
                   : (vld_reg[m_addr_reg] ? ram_rdata : '0);

    always_comb
    begin
        vld_next       = vld_reg;
        fwd_valid_next = fwd_valid_reg;
        if (m_inc_reg)
        begin
            vld_next[m_addr_reg] = 1'b1;
            fwd_valid_next       = 1'b1;
        end
        // a clear is younger than the increment finishing alongside it
        if (is_clear)
        begin
            vld_next       = '0;
            fwd_valid_next = 1'b0;
        end
    end

    assign res_val = m_bin_rd_reg ? bin_val : m_val_reg;
    assign res_pop = pop && !empty;

    always_comb
    begin
        res_wr_next  = res_wr_reg;
        res_rd_next  = res_rd_reg;
        res_cnt_next = res_cnt_reg;
        if (m_read_reg)
        begin
            res_wr_next = (res_wr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                        : res_wr_reg + OUT_PTR_W'(1);
        end
        if (res_pop)
        begin
            res_rd_next = (res_rd_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                        : res_rd_reg + OUT_PTR_W'(1);
        end
        if (m_read_reg && !res_pop)
        begin
            res_cnt_next = res_cnt_reg + OUT_CNT_W'(1);
        end
        else if (res_pop && !m_read_reg)
        begin
            res_cnt_next = res_cnt_reg - OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_CNT_N; i++)
            begin
                cnt_reg[i] <= '0;
            end
            vld_reg       <= '0;
            fwd_valid_reg <= 1'b0;
            m_inc_reg     <= 1'b0;
            m_read_reg    <= 1'b0;
            res_wr_reg    <= '0;
            res_rd_reg    <= '0;
            res_cnt_reg   <= '0;
        end
        else
        begin
            for (int i = 0; i < REG_CNT_N; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
            vld_reg       <= vld_next;
            fwd_valid_reg <= fwd_valid_next;
            m_inc_reg     <= bin_inc;
            m_read_reg    <= is_read;
            res_wr_reg    <= res_wr_next;
            res_rd_reg    <= res_rd_next;
            res_cnt_reg   <= res_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_inc_reg)
        begin
            fwd_addr_reg <= m_addr_reg;
            fwd_data_reg <= bin_val + VAL_W'(1);
        end
        m_bin_rd_reg <= bin_rd;
        m_addr_reg   <= ram_raddr;
        m_val_reg    <= flop_val;
        m_idx_reg    <= q_op.idx;
        if (m_read_reg)
        begin
            res_val_reg[res_wr_reg] <= res_val;
            res_idx_reg[res_wr_reg] <= m_idx_reg;
        end
    end

    assign empty         = (res_cnt_reg == '0);
    assign counter_value = res_val_reg[res_rd_reg];
    assign echoed_index  = res_idx_reg[res_rd_reg];

endmodule

>>> sv/mrs_checker.sv
// port-level checks for the region statistics core, bound to the top level
// depends on mrs_pkg and memory_region_statistics_core
module mrs_checker
    import mrs_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic [VAL_W-1:0]   counter_value,
    input logic [IDX_W-1:0]   echoed_index
);

    // an edge taken in reset leaves no result waiting and the input side open
    a_reset_state: assert property (@(posedge clk) !rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // an index past the last bin always answers zero
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (echoed_index >= IDX_W'(IDX_BINS + BIN_COUNT))) |-> (counter_value == '0))
        else $error("unused counter index gave a nonzero value");

    // a waiting result is not withdrawn
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped without a transfer");

    // a waiting result does not change
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(counter_value) && $stable(echoed_index)))
        else $error("result changed while stalled");

endmodule

bind memory_region_statistics_core mrs_checker u_mrs_checker (.*);

>>> dv/tb.sv
// testbench for memory_region_statistics_core: a tally scoreboard that predicts
// every counter read, plus tasks that drive the push side and drain the pop side
// depends on mrs_pkg and the core rtl
import mrs_pkg::*;

localparam logic [1:0] ACT_UNKNOWN  = 2'd3;
localparam logic [1:0] ST_COMMITTED = 2'd2;
localparam logic [1:0] ST_UNKNOWN   = 2'd3;
localparam logic [1:0] KIND_IMAGE   = 2'd1;
localparam logic [1:0] KIND_UNKNOWN = 2'd3;
localparam int IDX_IMAGE   = IDX_MAPPED + 1;
localparam int IDX_PRIVATE = IDX_MAPPED + 2;
localparam int IDX_UNUSED  = IDX_BINS + BIN_COUNT;

typedef struct packed {
    logic [1:0]         action;
    logic [BYTES_W-1:0] bytes;
    logic [1:0]         state;
    logic [1:0]         kind;
    logic [PROT_W-1:0]  prot;
    logic [IDX_W-1:0]   idx;
} region_item_t;

typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] idx;
} counter_readout_t;

class region_tally;
    logic [PAGES_W-1:0] page_counts [REG_CNT_N];
    logic [PAGES_W-1:0] span_bins [BIN_COUNT];
    counter_readout_t   expected_readouts [$];
    int                 mismatches;

    function new();
        wipe();
        mismatches = 0;
    endfunction

    function void wipe();
        foreach (page_counts[i]) page_counts[i] = '0;
        foreach (span_bins[i]) span_bins[i] = '0;
    endfunction

    function logic [VAL_W-1:0] counter_at(logic [IDX_W-1:0] idx);
        if (idx < REG_CNT_N)
            return page_counts[idx];
        if (idx < IDX_UNUSED)
            return span_bins[idx - IDX_BINS];
        return '0;
    endfunction

    function void note_transfer(region_item_t it);
        logic [PAGES_W-1:0] pages;
        counter_readout_t   rd;
        int                 top;
        int                 bin;
        int                 slot;
        bit                 found;
        pages = it.bytes[PAGE_SHIFT +: PAGES_W];
        if (it.action == ACT_CLEAR) begin
            wipe();
        end
        else if (it.action == ACT_READ) begin
            rd.value = counter_at(it.idx);
            rd.idx = it.idx;
            expected_readouts.push_back(rd);
        end
        else if (it.action == ACT_ACCOUNT) begin
            if (it.state == ST_FREE) begin
                top = -1;
                for (int b = 0; b < BYTES_W; b++)
                    if (it.bytes[b]) top = b;
                // zero-size and sub-page spans land in no bin
                bin = top - PAGE_SHIFT;
                if (bin >= 0) begin
                    if (bin > BIN_COUNT - 1) bin = BIN_COUNT - 1;
                    span_bins[bin] += 1;
                end
                page_counts[IDX_FREE] += pages;
            end
            else begin
                if (it.kind == KIND_MAPPED) slot = IDX_MAPPED;
                else if (it.kind == KIND_PRIVATE) slot = IDX_PRIVATE;
                else slot = IDX_IMAGE;
                page_counts[slot] += pages;
                if (it.state == ST_RESERVED) begin
                    page_counts[IDX_RESERVED] += pages;
                end
                else begin
                    // unknown state counts as committed
                    page_counts[IDX_COMMITTED] += pages;
                    if (it.prot[GUARD_BIT]) page_counts[IDX_GUARD] += pages;
                    found = 0;
                    for (int b = 0; b < ACC_N; b++) begin
                        if (!found && it.prot[b]) begin
                            page_counts[IDX_ACCESS + b] += pages;
                            found = 1;
                        end
                    end
                end
            end
        end
    endfunction

    task report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
        if (mismatches < 100)
            $display("mismatch on %s: got 0x%0h, want 0x%0h", what, got, want);
        mismatches++;
    endtask

    task check_readout(logic [VAL_W-1:0] value, logic [IDX_W-1:0] idx);
        counter_readout_t want;
        if (expected_readouts.size() == 0) begin
            report_mismatch("result with nothing pending", value, '0);
            return;
        end
        want = expected_readouts.pop_front();
        if (value !== want.value)
            report_mismatch($sformatf("counter_value idx %0d", want.idx), value, want.value);
        if (idx !== want.idx)
            report_mismatch("echoed_index", VAL_W'(idx), VAL_W'(want.idx));
    endtask
endclass

module tb;
    import mrs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [1:0]         action = '0;
    logic [BYTES_W-1:0] region_bytes = '0;
    logic [1:0]         region_state = '0;
    logic [1:0]         region_kind = '0;
    logic [PROT_W-1:0]  protect_bits = '0;
    logic [IDX_W-1:0]   counter_index = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [VAL_W-1:0]   counter_value;
    logic [IDX_W-1:0]   echoed_index;

    region_tally tally = new();
    int          send_idle = 0;
    int          recv_idle = 0;
    bit          hold_start = 0;
    int          hold_left = 0;
    int          cycles = 0;

    memory_region_statistics_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .action        (action),
        .region_bytes  (region_bytes),
        .region_state  (region_state),
        .region_kind   (region_kind),
        .protect_bits  (protect_bits),
        .counter_index (counter_index),
        .empty         (empty),
        .pop           (pop),
        .counter_value (counter_value),
        .echoed_index  (echoed_index)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: check each transfer, then pick pop for the next edge
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            tally.check_readout(counter_value, echoed_index);
        if (hold_start)
        begin
            hold_left = 150;
            hold_start = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic region_item_t mk(logic [1:0] act, logic [BYTES_W-1:0] bytes,
                                        logic [1:0] st, logic [1:0] kind,
                                        logic [PROT_W-1:0] prot, logic [IDX_W-1:0] idx);
        region_item_t it;
        it.action = act;
        it.bytes = bytes;
        it.state = st;
        it.kind = kind;
        it.prot = prot;
        it.idx = idx;
        return it;
    endfunction

    function automatic logic [BYTES_W-1:0] rand_bytes();
        int                 pick;
        int                 top;
        logic [BYTES_W-1:0] b;
        pick = $urandom_range(99);
        top = $urandom_range(0, BYTES_W - 1);
        b = BYTES_W'({$urandom, $urandom});
        if (pick < 5) return '0;
        if (pick < 15) return b;
        b = b & ((BYTES_W'(1) << (top + 1)) - BYTES_W'(1));
        b[top] = 1'b1;
        if (pick < 85) b[PAGE_SHIFT-1:0] = '0;
        return b;
    endfunction

    function automatic region_item_t rand_item();
        region_item_t it;
        int           pick;
        pick = $urandom_range(99);
        it.action = (pick < 2) ? ACT_CLEAR : (pick < 5) ? ACT_UNKNOWN :
                    (pick < 55) ? ACT_ACCOUNT : ACT_READ;
        it.bytes = rand_bytes();
        it.state = 2'($urandom_range(0, 3));
        it.kind = 2'($urandom_range(0, 3));
        pick = $urandom_range(99);
        if (pick < 50)
            it.prot = PROT_W'($urandom);
        else if (pick < 75)
            it.prot = PROT_W'(1 << $urandom_range(0, ACC_N - 1)) |
                      PROT_W'($urandom_range(0, 1) << GUARD_BIT);
        else
            it.prot = PROT_W'($urandom) & ~PROT_W'(7'h7F);
        if ($urandom_range(99) < 80)
            it.idx = IDX_W'($urandom_range(0, IDX_UNUSED - 1));
        else
            it.idx = IDX_W'($urandom_range(0, 63));
        return it;
    endfunction

    // one input transfer, with an optional idle gap first
    task automatic send_item(region_item_t it);
        if ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        push <= 1'b1;
        action <= it.action;
        region_bytes <= it.bytes;
        region_state <= it.state;
        region_kind <= it.kind;
        protect_bits <= it.prot;
        counter_index <= it.idx;
        @(posedge clk);
        while (full) @(posedge clk);
        tally.note_transfer(it);
    endtask

    task automatic send_random(int n);
        repeat (n) send_item(rand_item());
    endtask

    task automatic drain_results();
        push <= 1'b0;
        @(posedge clk);
        while (tally.expected_readouts.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 28;
        recv_idle = 81;
        // counters read zero after reset, unused indexes read zero
        send_item(mk(ACT_READ, '0, ST_FREE, KIND_MAPPED, '0, IDX_W'(IDX_FREE)));
        send_item(mk(ACT_READ, '0, ST_FREE, KIND_MAPPED, '0, IDX_W'(IDX_UNUSED)));
        send_item(mk(ACT_READ, '1, ST_UNKNOWN, KIND_UNKNOWN, '1, '1));
        // zero-size and sub-page free spans, smallest bin, largest size, then two reserved spans
        send_item(mk(ACT_ACCOUNT, '0, ST_FREE, KIND_MAPPED, '0, '0));
        send_item(mk(ACT_ACCOUNT, 48'hFFF, ST_FREE, KIND_IMAGE, '0, '0));
        send_item(mk(ACT_ACCOUNT, 48'h1000, ST_FREE, KIND_UNKNOWN, '1, '0));
        send_item(mk(ACT_ACCOUNT, '1, ST_FREE, KIND_PRIVATE, '0, '0));
        send_item(mk(ACT_ACCOUNT, 48'h5000, ST_RESERVED, KIND_MAPPED, '0, '0));
        send_item(mk(ACT_ACCOUNT, 48'h3000, ST_RESERVED, KIND_UNKNOWN, '1, '0));
        // committed: guard plus lowest access bit, no access bit, unknown state
        send_item(mk(ACT_ACCOUNT, '1, ST_COMMITTED, KIND_PRIVATE, 11'h101, '0));
        send_item(mk(ACT_ACCOUNT, 48'h2000, ST_COMMITTED, KIND_IMAGE, '0, '0));
        send_item(mk(ACT_ACCOUNT, 48'h7000, ST_UNKNOWN, KIND_MAPPED, 11'h7C0, '0));
        send_item(mk(ACT_ACCOUNT, 48'h1000, ST_COMMITTED, KIND_UNKNOWN, 11'h0FE, '0));
        send_item(mk(ACT_UNKNOWN, '1, ST_FREE, KIND_MAPPED, '1, IDX_W'(IDX_FREE)));
        send_item(mk(ACT_READ, '0, ST_FREE, KIND_MAPPED, '0, IDX_W'(IDX_FREE)));
        send_item(mk(ACT_READ, '0, ST_FREE, KIND_MAPPED, '0, IDX_W'(IDX_MAPPED)));
        send_item(mk(ACT_READ, '0, ST_FREE, KIND_MAPPED, '0, IDX_W'(IDX_IMAGE)));
        send_item(mk(ACT_READ, '0, ST_FREE, KIND_MAPPED, '0, IDX_W'(IDX_PRIVATE)));
        send_item(mk(ACT_READ, '0, ST_FREE, KIND_MAPPED, '0, IDX_W'(IDX_RESERVED)));
        send_item(mk(ACT_READ, '0, ST_FREE, KIND_MAPPED, '0, IDX_W'(IDX_COMMITTED)));
        send_item(mk(ACT_READ, '0, ST_FREE, KIND_MAPPED, '0, IDX_W'(IDX_GUARD)));
        send_item(mk(ACT_READ, '0, ST_FREE, KIND_MAPPED, '0, IDX_W'(IDX_ACCESS)));
        send_item(mk(ACT_READ, '0, ST_FREE, KIND_MAPPED, '0, IDX_W'(IDX_ACCESS + 6)));
        send_item(mk(ACT_READ, '0, ST_FREE, KIND_MAPPED, '0, IDX_W'(IDX_BINS)));
        send_item(mk(ACT_READ, '0, ST_FREE, KIND_MAPPED, '0, IDX_W'(IDX_UNUSED - 1)));
        send_item(mk(ACT_CLEAR, '0, ST_FREE, KIND_MAPPED, '0, '0));
        send_item(mk(ACT_READ, '0, ST_FREE, KIND_MAPPED, '0, IDX_W'(IDX_UNUSED - 1)));
        send_random(310);
        drain_results();

        send_idle = 81;
        recv_idle = 28;
        send_random(330);
        drain_results();

        // receiver stalls long while reads keep coming, so full must rise
        send_idle = 0;
        recv_idle = 0;
        hold_start = 1;
        repeat (40)
            send_item(mk(ACT_READ, '0, ST_FREE, KIND_MAPPED, '0,
                         IDX_W'($urandom_range(0, 63))));
        send_random(300);
        drain_results();

        repeat (20) @(posedge clk);
        if (tally.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

>>> filelist.f
sv/mrs_pkg.sv
sv/mrs_ram.sv
sv/mrs_front.sv
sv/mrs_op_queue.sv
sv/mrs_back.sv
sv/memory_region_statistics_core.sv
sv/mrs_checker.sv
dv/tb.sv
